[hw/rtl/cld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg: shared types and constants of the content-length deframer
// Character codes, the header name pattern, the byte class carried between
// the front and back parts, and the number parse phases.
// ----------------------------------------------------------------------------
package cld_pkg;

   localparam int unsigned NAME_LEN    = 15;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CFG_BITS    = 24;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 24'd65535;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                is_cr;
      logic                is_lf;
      logic                is_digit;
      logic [3:0]          digit_val;
      logic                is_space;
      logic [NAME_LEN-1:0] name_hits;
   } cld_class_type;

   typedef enum logic [3:0] {
      PH_NONE   = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } cld_phase_type;

   // "Content-Length:"
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h6E;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6E;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2D;
         4'd8:    c = 8'h4C;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6E;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         4'd14:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/cld_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_if: valid/ready channels of the content-length deframer
// Input byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface cld_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       in_body;
   logic       msg_last;
   logic       length_too_big;

   modport source (output valid, output out_byte, output in_body, output msg_last,
                   output length_too_big, input ready);
   modport sink   (input valid, input out_byte, input in_body, input msg_last,
                   input length_too_big, output ready);
endinterface

interface cld_csr_if;
   logic        valid;
   logic        ready;
   logic [23:0] max_body_length;

   modport source (output valid, output max_body_length, input ready);
   modport sink   (input valid, input max_body_length, output ready);
endinterface

[hw/rtl/cld_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_front: byte intake and classification
// Registers each accepted beat together with its character class and the
// per-position compare against the header name pattern.
// ----------------------------------------------------------------------------
module cld_front (
   input  logic               clock,
   input  logic               reset,
   cld_req_if.sink            req_if,
   output logic               push_valid,
   output cld_pkg::cld_class_type push_data,
   input  logic               push_ready
);
   import cld_pkg::*;

   logic          valid_ff, valid_in;
   cld_class_type data_ff, data_in;
   logic          take;

   assign req_if.ready = !valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;
   assign push_valid   = valid_ff;
   assign push_data    = data_ff;

   always_comb begin
      logic [7:0] c;
      logic [7:0] diff;
      c    = req_if.data_byte;
      diff = c - CHAR_ZERO;
      data_in.data_byte = c;
      data_in.is_cr     = (c == CHAR_CR);
      data_in.is_lf     = (c == CHAR_LF);
      data_in.is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      data_in.digit_val = diff[3:0];
      data_in.is_space  = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
                          (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
      for (int i = 0; i < NAME_LEN; i++) begin
         data_in.name_hits[i] = (c == name_char(4'(i)));
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/cld_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_queue: short queue between front and back
// Small first-in first-out buffer of classified beats.
// ----------------------------------------------------------------------------
module cld_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  cld_pkg::cld_class_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output cld_pkg::cld_class_type pop_data,
   input  logic               pop_ready
);
   import cld_pkg::*;

   localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_PTR   = PTR_BITS'(QUEUE_DEPTH - 1);

   cld_class_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/cld_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_back: message framing state and result register
// Tracks header terminator and name matches, parses the declared length,
// counts out the body and drives the result channel from a register.
// ----------------------------------------------------------------------------
module cld_back #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  cld_pkg::cld_class_type pop_data,
   output logic               pop_ready,
   input  logic [cld_pkg::CFG_BITS-1:0] max_body_length,
   cld_rsp_if.source          rsp_if
);
   import cld_pkg::*;

   localparam int unsigned CMP_BITS  = (LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS;
   localparam int unsigned PROD_BITS = LENGTH_BITS + 4;
   localparam logic [3:0]  NAME_LAST = 4'(NAME_LEN);

   logic                   in_body_ff, in_body_in;
   logic [1:0]             end_cnt_ff, end_cnt_in;
   logic [3:0]             name_cnt_ff, name_cnt_in;
   cld_phase_type          phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] decl_ff, decl_in;
   logic                   ovf_ff, ovf_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff;
   logic                   out_body_ff, out_body_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_big_ff, out_big_in;

   logic                   take;
   logic [CMP_BITS-1:0]    max_ext, mask_ext, lim_ext;
   logic [LENGTH_BITS-1:0] limit;
   logic [PROD_BITS-1:0]   acc_sum;
   logic                   add_now;
   logic                   end_hit;

   assign pop_ready = !out_valid_ff || rsp_if.ready;
   assign take      = pop_valid && pop_ready;

   assign max_ext  = CMP_BITS'(max_body_length);
   assign mask_ext = CMP_BITS'({LENGTH_BITS{1'b1}});
   assign lim_ext  = (max_ext < mask_ext) ? max_ext : mask_ext;
   assign limit    = lim_ext[LENGTH_BITS-1:0];

   assign acc_sum = (PROD_BITS'(decl_ff) << 3) + (PROD_BITS'(decl_ff) << 1)
                    + PROD_BITS'(pop_data.digit_val);

   always_comb begin
      in_body_in  = in_body_ff;
      end_cnt_in  = end_cnt_ff;
      name_cnt_in = name_cnt_ff;
      phase_in    = phase_ff;
      decl_in     = decl_ff;
      ovf_in      = ovf_ff;
      left_in     = left_ff;
      out_body_in = 1'b0;
      out_last_in = 1'b0;
      out_big_in  = 1'b0;
      add_now     = 1'b0;
      end_hit     = 1'b0;

      if (in_body_ff) begin
         out_body_in = 1'b1;
         if (left_ff > LENGTH_BITS'(1)) begin
            left_in = left_ff - 1'b1;
         end else begin
            out_last_in = 1'b1;
            out_big_in  = ovf_ff;
            in_body_in  = 1'b0;
            end_cnt_in  = '0;
            name_cnt_in = '0;
            phase_in    = PH_NONE;
            decl_in     = '0;
            ovf_in      = 1'b0;
            left_in     = '0;
         end
      end else begin
         // header name and length parse
         case (phase_ff)
            PH_NONE: begin
               if ((name_cnt_ff < NAME_LAST) && pop_data.name_hits[name_cnt_ff]) begin
                  name_cnt_in = name_cnt_ff + 1'b1;
               end else begin
                  name_cnt_in = pop_data.name_hits[0] ? 4'd1 : 4'd0;
               end
               if (name_cnt_in >= NAME_LAST) begin
                  phase_in    = PH_SKIP;
                  name_cnt_in = '0;
               end
            end
            PH_SKIP: begin
               if (pop_data.is_digit) begin
                  phase_in = PH_DIGITS;
                  add_now  = 1'b1;
               end else if (!pop_data.is_space) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DIGITS: begin
               if (pop_data.is_digit) begin
                  add_now = 1'b1;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         if (add_now) begin
            if (ovf_ff || (acc_sum > PROD_BITS'(limit))) begin
               decl_in = limit;
               ovf_in  = 1'b1;
            end else begin
               decl_in = acc_sum[LENGTH_BITS-1:0];
            end
         end

         // header terminator
         case (end_cnt_ff)
            2'd0: end_cnt_in = pop_data.is_cr ? 2'd1 : 2'd0;
            2'd1: end_cnt_in = pop_data.is_lf ? 2'd2 : (pop_data.is_cr ? 2'd1 : 2'd0);
            2'd2: end_cnt_in = pop_data.is_cr ? 2'd3 : 2'd0;
            2'd3: begin
               if (pop_data.is_lf) begin
                  end_cnt_in = 2'd0;
                  end_hit    = 1'b1;
               end else begin
                  end_cnt_in = pop_data.is_cr ? 2'd1 : 2'd0;
               end
            end
            default: end_cnt_in = 2'd0;
         endcase

         if (end_hit) begin
            if (decl_in == '0) begin
               out_last_in = 1'b1;
               out_big_in  = ovf_in;
               in_body_in  = 1'b0;
               end_cnt_in  = '0;
               name_cnt_in = '0;
               phase_in    = PH_NONE;
               decl_in     = '0;
               ovf_in      = 1'b0;
               left_in     = '0;
            end else begin
               in_body_in = 1'b1;
               left_in    = decl_in;
            end
         end
      end
   end

   always_comb begin
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff   <= 1'b0;
         end_cnt_ff   <= '0;
         name_cnt_ff  <= '0;
         phase_ff     <= PH_NONE;
         decl_ff      <= '0;
         ovf_ff       <= 1'b0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            in_body_ff  <= in_body_in;
            end_cnt_ff  <= end_cnt_in;
            name_cnt_ff <= name_cnt_in;
            phase_ff    <= phase_in;
            decl_ff     <= decl_in;
            ovf_ff      <= ovf_in;
            left_ff     <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff <= pop_data.data_byte;
         out_body_ff <= out_body_in;
         out_last_ff <= out_last_in;
         out_big_ff  <= out_big_in;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.out_byte       = out_byte_ff;
   assign rsp_if.in_body        = out_body_ff;
   assign rsp_if.msg_last       = out_last_ff;
   assign rsp_if.length_too_big = out_big_ff;

endmodule

[hw/rtl/content_length_message_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_length_message_deframer: text stream message framer
// Passes every byte of a text stream through and marks header or body and
// the last byte of each message; the body length is taken from the first
// "Content-Length:" header line, the header ends at CR LF CR LF.
//
// req_if: one input byte per beat. rsp_if: one result beat per input beat,
// in order, carrying the byte, its body flag, the last-byte flag and the
// oversize flag. csr_if: writes the largest accepted body length (reset
// 65535); write only while no beats are in flight.
//
// An accepted req_if beat passes the classify register, the two-entry queue
// and the result register to rsp_if. One beat is taken every cycle while
// rsp_if does not stall; the framing state in the back part updates once
// per accepted beat. Reset returns to the header phase with empty queue and
// result register. When rsp_if stalls the queue fills and req_if.ready
// drops after the front register and the queue are full; no beat is lost.
// ----------------------------------------------------------------------------
module content_length_message_deframer #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   cld_req_if.sink    req_if,
   cld_rsp_if.source  rsp_if,
   cld_csr_if.sink    csr_if
);
   import cld_pkg::*;

   logic                push_valid, push_ready;
   cld_class_type       push_data;
   logic                pop_valid, pop_ready;
   cld_class_type       pop_data;
   logic [CFG_BITS-1:0] max_len_ff, max_len_in;

   assign csr_if.ready = 1'b1;
   assign max_len_in   = (csr_if.valid && csr_if.ready) ? csr_if.max_body_length
                                                        : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= CFG_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   cld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   cld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   cld_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_data        (pop_data),
      .pop_ready       (pop_ready),
      .max_body_length (max_len_ff),
      .rsp_if          (rsp_if)
   );

endmodule
